/* rtl/fsmu_pkg.sv */
// Shared types, constants and the exponent table of the fibre stress and modulus unit.
`timescale 1ns / 1ps

package fsmu_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPERSION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIBER_MODULUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFENING    = 2'd2;

    localparam logic [14:0] KAPPA_RESET = 15'd0;
    localparam logic [31:0] K1_RESET    = 32'd65536;
    localparam logic [23:0] K2_RESET    = 24'd65536;

    localparam logic [16:0] ONE_Q16   = 17'h1_0000;
    localparam logic [48:0] RND_HALF  = 49'h8000;
    localparam logic [31:0] ONE_Q24   = 32'h0100_0000;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [61:0] Y_HALF    = 62'h2000_0000;
    localparam logic [31:0] INV3      = 32'hAAAA_AAAB;
    localparam logic [63:0] XLIM      = 64'h0000_4000_0000_0000;
    localparam logic [7:0]  HUGE_EXP  = 8'd255;

    localparam logic signed [8:0] SH_STRESS = 9'sd61;
    localparam logic signed [8:0] SH_MOD    = 9'sd76;

    localparam logic [47:0] CAP_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] CAP_NEG = 48'h8000_0000_0000;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [31:0] mb;
        logic [31:0] w;
    } t_side;

    function automatic logic [30:0] exp2_eighth(input logic [2:0] j);
        logic [30:0] v;
        case (j)
            3'd0:    v = 31'd1073741824;
            3'd1:    v = 31'd1170923762;
            3'd2:    v = 31'd1276901417;
            3'd3:    v = 31'd1392470869;
            3'd4:    v = 31'd1518500250;
            3'd5:    v = 31'd1655936265;
            3'd6:    v = 31'd1805811301;
            default: v = 31'd1969251188;
        endcase
        return v;
    endfunction

endpackage

/* rtl/fsmu_mul64.sv */
// Two-stage 64 by 64 bit unsigned multiplier built from 32 by 32 bit partial products.
`timescale 1ns / 1ps

module fsmu_mul64 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_valid,
    output logic [127:0]  o_p
);

    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic         r_v1, r_v2;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0]  * i_b[31:0];
            r_lh <= i_a[31:0]  * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
            r_hh <= i_a[63:32] * i_b[63:32];
            r_p  <= {r_hh, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0};
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;

endmodule

/* rtl/fsmu_clip.sv */
// Two-stage power-of-two scaling with truncation and clipping to a cap.
`timescale 1ns / 1ps

module fsmu_clip (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [127:0]        i_p,
    input  logic signed [8:0]   i_sh,
    input  logic [47:0]         i_cap,
    output logic                o_valid,
    output logic [47:0]         o_val,
    output logic                o_clip
);

    logic               w_left;
    logic signed [8:0]  w_nsh;
    logic [127:0]       n_r;
    logic [47:0]        w_lim;
    logic               n_cmpl;

    logic [127:0] r_r;
    logic         r_left, r_cmpl, r_v1, r_v2;
    logic [47:0]  r_cap1, r_val;
    logic         r_clip;
    logic         w_clip;

    always_comb begin
        w_left = i_sh > 9'sd0;
        w_nsh  = -i_sh;
        w_lim  = i_cap >> i_sh[7:0];
        n_r    = w_left ? (i_p << i_sh[7:0]) : (i_p >> w_nsh[6:0]);
        n_cmpl = i_p > {80'd0, w_lim};
    end

    assign w_clip = r_left ? r_cmpl : (r_r > {80'd0, r_cap1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r    <= n_r;
            r_left <= w_left;
            r_cmpl <= n_cmpl;
            r_cap1 <= i_cap;
            r_clip <= w_clip;
            r_val  <= w_clip ? r_cap1 : r_r[47:0];
        end
    end

    assign o_valid = r_v2;
    assign o_val   = r_val;
    assign o_clip  = r_clip;

endmodule

/* rtl/fsmu_exp.sv */
// Nine-stage base-two exponential pipeline: scaling by log2(e), table step and series.
`timescale 1ns / 1ps

module fsmu_exp import fsmu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [30:0]  i_x,
    input  t_side        i_side,
    output logic         o_valid,
    output logic [30:0]  o_mant,
    output logic [7:0]   o_n,
    output t_side        o_side
);

    logic [8:0]  r_v;
    t_side       r_side [9];

    logic [61:0] r1_xl;
    logic [6:0]  r2_n, r3_n, r4_n, r5_n, r6_n, r7_n, r8_n;
    logic [23:0] r2_f;
    logic [26:0] r3_t, r4_t, r5_t, r6_t, r7_t;
    logic [2:0]  r3_j, r4_j, r5_j, r6_j, r7_j;
    logic [57:0] r4_m, r6_m, r7_m;
    logic [59:0] r5_q;
    logic [61:0] r8_m;
    logic [30:0] r9_mant;
    logic [7:0]  r9_n;

    logic [61:0] w_y;
    logic [50:0] w_tp;
    logic [30:0] w_a4, w_a3, w_a2, w_p;

    always_comb begin
        w_y  = r1_xl + Y_HALF;
        w_tp = r2_f[20:0] * LN2_Q30;
        w_a4 = ONE_Q30 + {6'd0, r3_t[26:2]};
        w_a3 = ONE_Q30 + {4'd0, r5_q[59:33]};
        w_a2 = ONE_Q30 + {4'd0, r6_m[57:31]};
        w_p  = ONE_Q30 + {3'd0, r7_m[57:30]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < 9; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r1_xl <= i_x * LOG2E_Q30;
            r2_n  <= w_y[60:54];
            r2_f  <= w_y[53:30];
            r3_t  <= w_tp[50:24];
            r3_j  <= r2_f[23:21];
            r3_n  <= r2_n;
            r4_m  <= r3_t * w_a4;
            r4_t  <= r3_t;
            r4_j  <= r3_j;
            r4_n  <= r3_n;
            r5_q  <= r4_m[57:30] * INV3;
            r5_t  <= r4_t;
            r5_j  <= r4_j;
            r5_n  <= r4_n;
            r6_m  <= r5_t * w_a3;
            r6_t  <= r5_t;
            r6_j  <= r5_j;
            r6_n  <= r5_n;
            r7_m  <= r6_t * w_a2;
            r7_t  <= r6_t;
            r7_j  <= r6_j;
            r7_n  <= r6_n;
            r8_m  <= exp2_eighth(r7_j) * w_p;
            r8_n  <= r7_n;
            r9_mant <= r_side[7].ovf ? ONE_Q30 : r8_m[60:30];
            r9_n    <= r_side[7].ovf ? HUGE_EXP : {1'b0, r8_n};
        end
    end

    assign o_valid = r_v[8];
    assign o_mant  = r9_mant;
    assign o_n     = r9_n;
    assign o_side  = r_side[8];

endmodule

/* rtl/fiber_stress_modulus_unit.sv */
// Fibre stress and modulus unit: front stages, exponential, multipliers, clip, output register.
// Throughput one beat per cycle; the whole pipeline advances while the output is empty or taken.
// Exponential is a nine-stage series pipeline, final products are split 64x64 multipliers.
// Reset (i_rst_n low, synchronous) clears the valid bits and loads kappa 0, k1 1.0, k2 1.0.
// Configuration writes are taken every cycle; coefficient products are then registered.
`timescale 1ns / 1ps

module fiber_stress_modulus_unit import fsmu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // stretch_fiber[31:0], stretch_cross[63:32]
    input  logic [63:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // stress_fiber[47:0], stress_cross[95:48], mod_ff[142:96], mod_fc[189:143],
    // mod_cc[236:190], zero pad[239:237]
    output logic [239:0]         m_axis_tdata,
    // saturated[0]
    output logic                 m_axis_tuser
);

    logic [14:0] r_kappa;
    logic [31:0] r_k1;
    logic [23:0] r_k2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kappa <= KAPPA_RESET;
            r_k1    <= K1_RESET;
            r_k2    <= K2_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DISPERSION:    r_kappa <= i_cfg_data[14:0];
                CFG_FIBER_MODULUS: r_k1    <= i_cfg_data;
                CFG_STIFFENING:    r_k2    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [16:0] w_a;
    logic [48:0] r_ca;
    logic [46:0] r_ck;
    logic [32:0] r_aa;
    logic [31:0] r_ak;
    logic [29:0] r_kk;
    logic [63:0] r_caa, r_cak, r_ckk;

    assign w_a = ONE_Q16 - {2'd0, r_kappa};

    always_ff @(posedge i_clk) begin
        r_ca  <= r_k1 * w_a;
        r_ck  <= r_k1 * r_kappa;
        r_aa  <= w_a * w_a;
        r_ak  <= w_a * r_kappa;
        r_kk  <= r_kappa * r_kappa;
        r_caa <= r_k1 * r_aa;
        r_cak <= r_k1 * r_ak;
        r_ckk <= r_k1 * r_kk;
    end

    logic w_en;
    logic r_out_valid;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic        r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [48:0] r1_sa;
    logic [46:0] r1_sk;
    logic        r2_neg, r3_neg, r4_neg;
    logic [31:0] r2_mb, r3_mb, r4_mb;
    logic [63:0] r3_sq;
    logic [55:0] r4_p0;
    logic [31:0] r4_p1;
    logic [30:0] r5_x;
    t_side       r5_side;

    logic [48:0] w_sum;
    logic [31:0] w_r;
    logic        w_neg;
    logic [39:0] w_b2;
    logic [63:0] w_kb;
    logic        w_ovf;
    logic [30:0] w_x;

    always_comb begin
        w_sum = r1_sa + {2'd0, r1_sk} + RND_HALF;
        w_r   = w_sum[47:16];
        w_neg = w_r < ONE_Q24;
        w_b2  = r3_sq[63:24];
        w_kb  = {8'd0, r4_p0} + {r4_p1, 32'd0};
        w_ovf = w_kb > XLIM;
        w_x   = w_kb[46:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sa  <= w_a * s_axis_tdata[31:0];
            r1_sk  <= r_kappa * s_axis_tdata[63:32];
            r2_neg <= w_neg;
            r2_mb  <= w_neg ? (ONE_Q24 - w_r) : (w_r - ONE_Q24);
            r3_sq  <= r2_mb * r2_mb;
            r3_neg <= r2_neg;
            r3_mb  <= r2_mb;
            r4_p0  <= r_k2 * w_b2[31:0];
            r4_p1  <= r_k2 * w_b2[39:32];
            r4_neg <= r3_neg;
            r4_mb  <= r3_mb;
            r5_x         <= w_x;
            r5_side.neg  <= r4_neg;
            r5_side.ovf  <= w_ovf;
            r5_side.mb   <= r4_mb;
            r5_side.w    <= w_ovf ? ONE_Q24 : (ONE_Q24 + {w_x, 1'b0});
        end
    end

    logic        w_ev;
    logic [30:0] w_mant;
    logic [7:0]  w_n;
    t_side       w_es;

    fsmu_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_v),
        .i_x     (r5_x),
        .i_side  (r5_side),
        .o_valid (w_ev),
        .o_mant  (w_mant),
        .o_n     (w_n),
        .o_side  (w_es)
    );

    logic                r6_v;
    logic [62:0]         r6_bs, r6_bw;
    logic signed [8:0]   r6_ss, r6_sm, r7_ss, r7_sm, r8_ss, r8_sm;
    logic [47:0]         r6_cap, r7_cap, r8_cap;
    logic [4:0]          r_neg_d, r_ovf_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= w_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_bs   <= w_es.mb * w_mant;
            r6_bw   <= w_es.w * w_mant;
            r6_ss   <= $signed({1'b0, w_n}) - SH_STRESS;
            r6_sm   <= $signed({1'b0, w_n}) - SH_MOD;
            r6_cap  <= w_es.neg ? CAP_NEG : CAP_POS;
            r7_ss   <= r6_ss;
            r7_sm   <= r6_sm;
            r7_cap  <= r6_cap;
            r8_ss   <= r7_ss;
            r8_sm   <= r7_sm;
            r8_cap  <= r7_cap;
            r_neg_d <= {r_neg_d[3:0], w_es.neg};
            r_ovf_d <= {r_ovf_d[3:0], w_es.ovf};
        end
    end

    logic [63:0]  w_ma [5];
    logic [63:0]  w_mb [5];
    logic [127:0] w_mp [5];
    logic [4:0]   w_mv;
    logic signed [8:0] w_sh [5];
    logic [47:0]  w_cap [5];
    logic [47:0]  w_cval [5];
    logic [4:0]   w_cclip;
    logic [4:0]   w_cv;

    always_comb begin
        w_ma[0] = {15'd0, r_ca};
        w_ma[1] = {17'd0, r_ck};
        w_ma[2] = r_caa;
        w_ma[3] = r_cak;
        w_ma[4] = r_ckk;
        w_mb[0] = {1'b0, r6_bs};
        w_mb[1] = {1'b0, r6_bs};
        w_mb[2] = {1'b0, r6_bw};
        w_mb[3] = {1'b0, r6_bw};
        w_mb[4] = {1'b0, r6_bw};
        w_sh[0] = r8_ss;
        w_sh[1] = r8_ss;
        w_sh[2] = r8_sm;
        w_sh[3] = r8_sm;
        w_sh[4] = r8_sm;
        w_cap[0] = r8_cap;
        w_cap[1] = r8_cap;
        w_cap[2] = CAP_POS;
        w_cap[3] = CAP_POS;
        w_cap[4] = CAP_POS;
    end

    for (genvar g = 0; g < 5; g++) begin : g_out
        fsmu_mul64 u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r6_v),
            .i_a     (w_ma[g]),
            .i_b     (w_mb[g]),
            .o_valid (w_mv[g]),
            .o_p     (w_mp[g])
        );

        fsmu_clip u_clip (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_mv[g]),
            .i_p     (w_mp[g]),
            .i_sh    (w_sh[g]),
            .i_cap   (w_cap[g]),
            .o_valid (w_cv[g]),
            .o_val   (w_cval[g]),
            .o_clip  (w_cclip[g])
        );
    end

    logic [47:0] r_sf, r_sc;
    logic [46:0] r_mff, r_mfc, r_mcc;
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= &w_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sf  <= r_neg_d[4] ? (48'd0 - w_cval[0]) : w_cval[0];
            r_sc  <= r_neg_d[4] ? (48'd0 - w_cval[1]) : w_cval[1];
            r_mff <= w_cval[2][46:0];
            r_mfc <= w_cval[3][46:0];
            r_mcc <= w_cval[4][46:0];
            r_sat <= r_ovf_d[4] || (|w_cclip);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_mcc, r_mfc, r_mff, r_sc, r_sf};
    assign m_axis_tuser  = r_sat;

    a_stress_sign : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !((r_sf[47] && !r_sc[47] && r_sc != 48'd0) ||
                          (r_sc[47] && !r_sf[47] && r_sf != 48'd0)))
        else $error("stress components differ in sign");

    a_stress_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_sf[47] |-> r_sf >= r_sc)
        else $error("cross stress exceeds fibre stress");

    a_mod_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_mff >= r_mfc) && (r_mfc >= r_mcc))
        else $error("modulus entries out of order");

    a_zero_mod : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_mff == 47'd0 |-> r_sf == 48'd0 && r_sc == 48'd0)
        else $error("stress without modulus");

endmodule

/* dv/fiber_stress_modulus_unit_test.sv */
// Self-checking testbench of the fibre stress and modulus unit: directed table, then random beats.
`timescale 1ns / 1ps

module fiber_stress_modulus_unit_test;
    import fsmu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [63:0] M47 = 64'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic        sat;
        logic [46:0] cc;
        logic [46:0] fc;
        logic [46:0] ff;
        logic [47:0] sc;
        logic [47:0] sf;
    } t_result;

    typedef struct {
        logic [31:0] c11;
        logic [31:0] c22;
        bit          typed;
        t_result     res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [239:0]         m_axis_tdata;
    logic                 m_axis_tuser;

    logic [14:0] kappa_q = KAPPA_RESET;
    logic [31:0] k1_q = K1_RESET;
    logic [23:0] k2_q = K2_RESET;

    t_result stress_q[$];
    int      errors = 0;
    int      idle_in = 0;
    int      stall_out = 0;

    fiber_stress_modulus_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] shift_clip(input logic [63:0] a, input logic [63:0] b,
                                               input int rs, input logic [63:0] cap,
                                               inout bit sat);
        logic [127:0] p;
        logic [63:0]  lo;
        int           bl;
        p = {64'd0, a} * {64'd0, b};
        if (rs >= 0) begin
            if (rs >= 128) return 64'd0;
            p = p >> rs;
            if (p > {64'd0, cap}) begin
                sat = 1'b1;
                return cap;
            end
            return p[63:0];
        end
        if (p == 0) return 64'd0;
        if (p[127:64] != 0) begin
            sat = 1'b1;
            return cap;
        end
        lo = p[63:0];
        bl = 0;
        for (int i = 0; i < 64; i++) if (lo[i]) bl = i + 1;
        if (bl - rs > 63) begin
            sat = 1'b1;
            return cap;
        end
        lo = lo << (-rs);
        if (lo > cap) begin
            sat = 1'b1;
            return cap;
        end
        return lo;
    endfunction

    function automatic t_result fibre_response(input logic [31:0] c11, input logic [31:0] c22);
        logic [63:0] kap, k1, k2, a, sum, r, mb, mh, ml, b2, mant, w, mag, cap;
        logic [63:0] x, y, f, rr, t, a4, a3, a2, p;
        logic [63:0] table_v [8];
        bit          neg, sat;
        int          n;
        t_result     res;
        table_v = '{64'd1073741824, 64'd1170923762, 64'd1276901417, 64'd1392470869,
                    64'd1518500250, 64'd1655936265, 64'd1805811301, 64'd1969251188};
        kap = kappa_q;
        k1 = k1_q;
        k2 = k2_q;
        sat = 1'b0;
        a = 64'd65536 - kap;
        sum = a * c11 + kap * c22;
        r = (sum + 64'd32768) >> 16;
        neg = r < 64'h100_0000;
        mb = neg ? 64'h100_0000 - r : r - 64'h100_0000;
        mh = mb >> 12;
        ml = mb & 64'hFFF;
        b2 = mh * mh + ((((64'd2 * mh * ml) << 12) + ml * ml) >> 24);
        if (k2 != 0 && b2 > XLIM / k2) begin
            sat = 1'b1;
            mant = 64'h4000_0000;
            n = HUGE_EXP;
            w = 64'h100_0000;
        end else begin
            x = (k2 * b2) >> 16;
            y = (x * 64'd1549082005 + 64'h2000_0000) >> 30;
            f = y & 64'hFF_FFFF;
            rr = f & 64'h1F_FFFF;
            t = (rr * 64'd744261118) >> 24;
            a4 = 64'h4000_0000 + (t >> 2);
            a3 = 64'h4000_0000 + ((t * a4) >> 30) / 64'd3;
            a2 = 64'h4000_0000 + (((t * a3) >> 30) >> 1);
            p = 64'h4000_0000 + ((t * a2) >> 30);
            mant = (table_v[f[23:21]] * p) >> 30;
            n = int'(y >> 24);
            w = 64'h100_0000 + 64'd2 * x;
        end
        cap = neg ? M47 + 64'd1 : M47;
        mag = shift_clip(k1 * a, mb * mant, 61 - n, cap, sat);
        res.sf = neg ? 48'(64'd0 - mag) : mag[47:0];
        mag = shift_clip(k1 * kap, mb * mant, 61 - n, cap, sat);
        res.sc = neg ? 48'(64'd0 - mag) : mag[47:0];
        res.ff = 47'(shift_clip(k1 * (a * a), w * mant, 76 - n, M47, sat));
        res.fc = 47'(shift_clip(k1 * (a * kap), w * mant, 76 - n, M47, sat));
        res.cc = 47'(shift_clip(k1 * (kap * kap), w * mant, 76 - n, M47, sat));
        res.sat = sat;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DISPERSION:    kappa_q = val[14:0];
            CFG_FIBER_MODULUS: k1_q = val;
            CFG_STIFFENING:    k2_q = val[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (stress_q.size() == 0);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic send_beat(input logic [31:0] c11, input logic [31:0] c22,
                             input bit typed, input t_result res);
        while ($urandom_range(99) < idle_in) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c22, c11};
        do @(posedge i_clk); while (!s_axis_tready);
        stress_q.push_back(typed ? res : fibre_response(c11, c22));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_stretch();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'h100_0000 + $urandom_range(32'h10_0000) - 32'h8_0000;
            2: return 32'h100_0000 + $urandom_range(32'h100) - 32'h80;
            default: return $urandom_range(32'h400_0000);
        endcase
    endfunction

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_out);

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[236:0]};
            if (stress_q.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end else begin
                want = stress_q.pop_front();
                if (got.sf !== want.sf) begin
                    $display("%0t: stress_fiber exp %h got %h", $time, want.sf, got.sf);
                    errors++;
                end
                if (got.sc !== want.sc) begin
                    $display("%0t: stress_cross exp %h got %h", $time, want.sc, got.sc);
                    errors++;
                end
                if (got.ff !== want.ff) begin
                    $display("%0t: mod_ff exp %h got %h", $time, want.ff, got.ff);
                    errors++;
                end
                if (got.fc !== want.fc) begin
                    $display("%0t: mod_fc exp %h got %h", $time, want.fc, got.fc);
                    errors++;
                end
                if (got.cc !== want.cc) begin
                    $display("%0t: mod_cc exp %h got %h", $time, want.cc, got.cc);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("fiber_stress_modulus_unit test failed");
        $finish;
    end

    initial begin
        t_row    rows[12];
        t_result none;
        int      count;
        none = '0;
        rows[0] = '{32'h100_0000, 32'h0, 1'b1, '{1'b0, 47'd0, 47'd0, 47'd67108864, 48'd0, 48'd0}};
        rows[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                    '{1'b1, 47'd0, 47'd0, M47[46:0], 48'd0, M47[47:0]}};
        rows[2] = '{32'h0, 32'h0, 1'b0, none};
        rows[3] = '{32'h0, 32'hFFFF_FFFF, 1'b0, none};
        rows[4] = '{32'hFFFF_FFFF, 32'h0, 1'b0, none};
        rows[5] = '{32'h100_0001, 32'h100_0000, 1'b0, none};
        rows[6] = '{32'hFF_FFFF, 32'h100_0000, 1'b0, none};
        rows[7] = '{32'h180_0000, 32'h80_0000, 1'b0, none};
        rows[8] = '{32'h80_0000, 32'h180_0000, 1'b0, none};
        rows[9] = '{32'h300_0000, 32'h200_0000, 1'b0, none};
        rows[10] = '{32'h900_0000, 32'h100_0000, 1'b0, none};
        rows[11] = '{32'hAAAA_5555, 32'h5555_AAAA, 1'b0, none};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[i]) send_beat(rows[i].c11, rows[i].c22, rows[i].typed, rows[i].res);
        s_axis_tvalid <= 1'b0;
        count = 0;
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_DISPERSION, 32'd32767);
                    write_reg(CFG_FIBER_MODULUS, 32'hFFFF_FFFF);
                    write_reg(CFG_STIFFENING, 32'hFF_FFFF);
                end
                1: begin
                    write_reg(CFG_DISPERSION, 32'd21627);
                    write_reg(CFG_FIBER_MODULUS, 32'd65536);
                    write_reg(CFG_STIFFENING, 32'd0);
                end
                2: begin
                    write_reg(CFG_DISPERSION, 32'd0);
                    write_reg(CFG_FIBER_MODULUS, 32'd0);
                    write_reg(CFG_UNUSED, $urandom());
                end
                default: begin
                    write_reg(CFG_DISPERSION, $urandom_range(21627));
                    write_reg(CFG_FIBER_MODULUS, $urandom_range(32'h10_0000, 32'h100));
                    write_reg(CFG_STIFFENING, $urandom_range(32'h4_0000));
                end
            endcase
            drain();
            repeat (115) begin
                idle_in = (count / 40) % 4 == 1 ? 70 : (count / 40) % 4 == 3 ? 25 : 0;
                stall_out = (count / 40) % 4 == 2 ? 70 : (count / 40) % 4 == 3 ? 25 : 0;
                send_beat(rand_stretch(), rand_stretch(), 1'b0, none);
                count++;
            end
            s_axis_tvalid <= 1'b0;
        end
        stall_out = 0;
        wait (stress_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("fiber_stress_modulus_unit test passed");
        end else begin
            $display("fiber_stress_modulus_unit test failed");
        end
        $finish;
    end

endmodule
